// File: rtl/bcld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcld_pkg
// Shared types and codes for the button click / long-press detector.
// ----------------------------------------------------------------------------
package bcld_pkg;

	// Event codes reported with each word
	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_PRESS   = 3'd1,
		EV_RELEASE = 3'd2,
		EV_CLICKS  = 3'd3,
		EV_LONG    = 3'd4
	} event_kind_t;

	// Configuration register indexes
	localparam logic [7:0] REG_SETTLE_TIME    = 8'd0;
	localparam logic [7:0] REG_LONG_THRESHOLD = 8'd1;
	localparam logic [7:0] REG_CLICK_GAP      = 8'd2;
	localparam logic [7:0] REG_REPEAT_IVL     = 8'd3;

	// Register reset values
	localparam logic [15:0] SETTLE_TIME_RST    = 16'd10;
	localparam logic [15:0] LONG_THRESHOLD_RST = 16'd1000;
	localparam logic [15:0] CLICK_GAP_RST      = 16'd200;
	localparam logic [15:0] REPEAT_IVL_RST     = 16'd100;

	// Saturation limits
	localparam logic [7:0]  CLICK_MAX = 8'hFF;
	localparam logic [15:0] HOLD_MAX  = 16'hFFFF;

	typedef struct packed {
		logic [15:0] settle_time;
		logic [15:0] long_press_threshold;
		logic [15:0] click_gap;
		logic [15:0] repeat_interval;
	} cfg_t;

	typedef struct packed {
		logic        button_state;
		logic [15:0] event_count;
		event_kind_t event_kind;
	} result_t;

endpackage
`default_nettype wire

// File: rtl/bcld_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcld_core
// Debounce, click burst and long-press state with one-poll update logic.
// ----------------------------------------------------------------------------
module bcld_core
	import bcld_pkg::*;
#(
	parameter int TIME_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic [TIME_WIDTH-1:0] now,
	input  wire logic                  sample,
	input  cfg_t                       cfg,
	output result_t                    res
);

	logic                  stable_q, pend_q;
	logic [TIME_WIDTH-1:0] pend_start_q, press_stamp_q, release_stamp_q, repeat_stamp_q;
	logic [15:0]           hold_q;
	logic [7:0]            click_q;

	logic                  stable_d, pend_d;
	logic [TIME_WIDTH-1:0] pend_start_d, press_stamp_d, release_stamp_d, repeat_stamp_d;
	logic [15:0]           hold_d;
	logic [7:0]            click_d;
	event_kind_t           kind;
	logic [15:0]           count;

	// Evaluate one poll against the current state
	always_comb begin
		stable_d        = stable_q;
		pend_d          = pend_q;
		pend_start_d    = pend_start_q;
		press_stamp_d   = press_stamp_q;
		release_stamp_d = release_stamp_q;
		repeat_stamp_d  = repeat_stamp_q;
		hold_d          = hold_q;
		click_d         = click_q;
		kind            = EV_NONE;
		count           = '0;

		// Debounce: commit a re-sampled level after the settle wait
		if (pend_q) begin
			if ((now - pend_start_q) >= TIME_WIDTH'(cfg.settle_time)) begin
				if (sample != stable_q) begin
					if (sample) begin
						press_stamp_d = now;
						kind          = EV_PRESS;
					end else begin
						release_stamp_d = now;
						kind            = EV_RELEASE;
						hold_d          = '0;
						if ((now - press_stamp_q) < TIME_WIDTH'(cfg.long_press_threshold)) begin
							if (click_q != CLICK_MAX) click_d = click_q + 8'd1;
						end else begin
							click_d = '0;
						end
					end
				end
				stable_d = sample;
				pend_d   = 1'b0;
			end
		end else if (sample != stable_q) begin
			pend_start_d = now;
			pend_d       = 1'b1;
		end

		// Long-press ticks while held, click report while released
		if (stable_d) begin
			if (hold_d == '0) begin
				if ((now - press_stamp_d) > TIME_WIDTH'(cfg.long_press_threshold)) begin
					hold_d         = 16'd1;
					repeat_stamp_d = now;
					kind           = EV_LONG;
					count          = 16'd1;
				end
			end else if ((now - repeat_stamp_d) > TIME_WIDTH'(cfg.repeat_interval)) begin
				repeat_stamp_d = now;
				if (hold_d != HOLD_MAX) hold_d = hold_d + 16'd1;
				kind  = EV_LONG;
				count = hold_d;
			end
		end else if (click_d != '0 && (now - release_stamp_d) > TIME_WIDTH'(cfg.click_gap)) begin
			kind    = EV_CLICKS;
			count   = {8'd0, click_d};
			click_d = '0;
		end

		res.event_kind   = kind;
		res.event_count  = count;
		res.button_state = stable_d;
	end

	// Advance state on each processed poll
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q        <= 1'b0;
			pend_q          <= 1'b0;
			pend_start_q    <= '0;
			press_stamp_q   <= '0;
			release_stamp_q <= '0;
			repeat_stamp_q  <= '0;
			hold_q          <= '0;
			click_q         <= '0;
		end else if (en) begin
			stable_q        <= stable_d;
			pend_q          <= pend_d;
			pend_start_q    <= pend_start_d;
			press_stamp_q   <= press_stamp_d;
			release_stamp_q <= release_stamp_d;
			repeat_stamp_q  <= repeat_stamp_d;
			hold_q          <= hold_d;
			click_q         <= click_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/button_click_longpress_detector_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_click_longpress_detector_unit
// Debounced button with press/release, multi-click and long-press events.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one poll word per handshake (tick counter value, raw pin,
//   pin active low). m_* channel: exactly one result word per poll (event
//   kind, event count, debounced state). cfg_* channel: register writes,
//   always ready; indexes above 3 are dropped. Write only while idle.
//   Path: a poll passes the input register, then the result register, on
//   its way to m_* (one input register, one result register). Throughput:
//   one poll per cycle while m_tready keeps the result register draining;
//   the debounce/click/hold update is a single pass of subtract and compare
//   logic from the input register into the state and result registers.
//   Reset: state clears to released with no pending change, counts zero,
//   registers return to 10 / 1000 / 200 / 100 ticks.
//   Stall: when m_tready is low the result word holds, the input register
//   keeps one more poll, then s_tready drops until the result is taken.
//   Only the low TIME_WIDTH bits of the tick counter are used; differences
//   wrap modulo 2^TIME_WIDTH.
// ----------------------------------------------------------------------------
module button_click_longpress_detector_unit
	import bcld_pkg::*;
#(
	parameter int TIME_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // [31:0] time_now, [32] pin_level, rest zero
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [2:0] event_kind, [18:3] event_count,
	                                    // [19] button_state, rest zero
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	cfg_t                  cfg_q;
	logic                  valid_s1;
	logic [TIME_WIDTH-1:0] time_s1;
	logic                  sample_s1;
	logic                  out_valid_q;
	result_t               out_q;
	result_t               res;
	logic                  advance;
	logic                  proc;

	assign cfg_ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_time          <= SETTLE_TIME_RST;
			cfg_q.long_press_threshold <= LONG_THRESHOLD_RST;
			cfg_q.click_gap            <= CLICK_GAP_RST;
			cfg_q.repeat_interval      <= REPEAT_IVL_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SETTLE_TIME:    cfg_q.settle_time          <= cfg_data;
				REG_LONG_THRESHOLD: cfg_q.long_press_threshold <= cfg_data;
				REG_CLICK_GAP:      cfg_q.click_gap            <= cfg_data;
				REG_REPEAT_IVL:     cfg_q.repeat_interval      <= cfg_data;
				default:            ;
			endcase
		end
	end

	// Flow control: result register free or being drained
	assign advance  = !out_valid_q || m_tready;
	assign proc     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			time_s1   <= s_tdata[TIME_WIDTH-1:0];
			sample_s1 <= ~s_tdata[32];
		end
	end

	bcld_core #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (proc),
		.now    (time_s1),
		.sample (sample_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_q.button_state, out_q.event_count, out_q.event_kind};

endmodule
`default_nettype wire

// File: tb/bcld_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcld_event_checker
// Watches the poll, result and register channels of the button detector.
// Each poll word is run through a local copy of the debounce, click and
// long-press state to compute the result word it must cause. Each result
// word is then compared field by field with the oldest computed one.
// ----------------------------------------------------------------------------
module bcld_event_checker
	import bcld_pkg::*;
#(
	parameter int TIME_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] time_now, [32] pin_level, rest zero
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // [2:0] event_kind, [18:3] event_count,
	                               // [19] button_state, rest zero
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          errors,
	output int          words_due
);

	localparam logic [31:0] TMASK = 32'hFFFF_FFFF >> (32 - TIME_WIDTH);

	// Local copy of the register file and the detector state
	cfg_t        regs;
	logic        held;
	logic        settling;
	logic [31:0] settle_from;
	logic [31:0] pressed_at;
	logic [31:0] released_at;
	logic [31:0] repeated_at;
	logic [15:0] long_ticks;
	logic [7:0]  click_run;

	result_t     due_events[$];
	int          mism;

	function automatic logic [31:0] ticks_since(input logic [31:0] now, input logic [31:0] then);
		return (now - then) & TMASK;
	endfunction

	// Advance the detector by one poll and return the word it reports
	function automatic result_t poll_outcome(input logic [31:0] stamp, input logic pin);
		logic [31:0] now;
		logic        pressed;
		event_kind_t kind;
		logic [15:0] count;
		result_t     res;
		now     = stamp & TMASK;
		pressed = ~pin;
		kind    = EV_NONE;
		count   = 16'd0;

		// Debounce: re-sample once the settle time has passed
		if (settling) begin
			if (ticks_since(now, settle_from) >= {16'd0, regs.settle_time}) begin
				if (pressed != held) begin
					if (pressed) begin
						pressed_at = now;
						kind = EV_PRESS;
					end else begin
						released_at = now;
						kind = EV_RELEASE;
						long_ticks = 16'd0;
						if (ticks_since(released_at, pressed_at) <
						    {16'd0, regs.long_press_threshold}) begin
							if (click_run != CLICK_MAX) click_run = click_run + 8'd1;
						end else begin
							click_run = 8'd0;
						end
					end
				end
				held = pressed;
				settling = 1'b0;
			end
		end else if (pressed != held) begin
			settle_from = now;
			settling = 1'b1;
		end

		// Long-press ticks while held, click report once released long enough
		if (held) begin
			if (long_ticks == 16'd0) begin
				if (ticks_since(now, pressed_at) > {16'd0, regs.long_press_threshold}) begin
					long_ticks = 16'd1;
					repeated_at = now;
					kind = EV_LONG;
					count = long_ticks;
				end
			end else if (ticks_since(now, repeated_at) > {16'd0, regs.repeat_interval}) begin
				repeated_at = now;
				if (long_ticks != HOLD_MAX) long_ticks = long_ticks + 16'd1;
				kind = EV_LONG;
				count = long_ticks;
			end
		end else if (click_run != 8'd0 &&
		             ticks_since(now, released_at) > {16'd0, regs.click_gap}) begin
			kind = EV_CLICKS;
			count = {8'd0, click_run};
			click_run = 8'd0;
		end

		res.event_kind   = kind;
		res.event_count  = count;
		res.button_state = held;
		return res;
	endfunction

	// Track register writes, queue predictions, compare result words
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			regs.settle_time          = SETTLE_TIME_RST;
			regs.long_press_threshold = LONG_THRESHOLD_RST;
			regs.click_gap            = CLICK_GAP_RST;
			regs.repeat_interval      = REPEAT_IVL_RST;
			held        = 1'b0;
			settling    = 1'b0;
			settle_from = '0;
			pressed_at  = '0;
			released_at = '0;
			repeated_at = '0;
			long_ticks  = '0;
			click_run   = '0;
			due_events.delete();
			mism = 0;
			errors    <= 0;
			words_due <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SETTLE_TIME:    regs.settle_time          = cfg_data;
					REG_LONG_THRESHOLD: regs.long_press_threshold = cfg_data;
					REG_CLICK_GAP:      regs.click_gap            = cfg_data;
					REG_REPEAT_IVL:     regs.repeat_interval      = cfg_data;
					default: ;
				endcase
			end

			if (s_tvalid && s_tready)
				due_events.push_back(poll_outcome(s_tdata[31:0], s_tdata[32]));

			if (m_tvalid && m_tready) begin
				if (due_events.size() == 0) begin
					$error("result word %h with no poll waiting", m_tdata);
					mism++;
				end else begin
					want = due_events.pop_front();
					if (m_tdata[2:0] !== want.event_kind) begin
						$error("event_kind: expected %0d, got %0d", want.event_kind, m_tdata[2:0]);
						mism++;
					end
					if (m_tdata[18:3] !== want.event_count) begin
						$error("event_count: expected %0d, got %0d", want.event_count,
						       m_tdata[18:3]);
						mism++;
					end
					if (m_tdata[19] !== want.button_state) begin
						$error("button_state: expected %0d, got %0d", want.button_state,
						       m_tdata[19]);
						mism++;
					end
					if (m_tdata[23:20] !== 4'd0) begin
						$error("padding: expected 0, got %h", m_tdata[23:20]);
						mism++;
					end
				end
			end

			errors    <= mism;
			words_due <= due_events.size();
		end
	end

endmodule

// File: tb/button_click_longpress_detector_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_longpress_detector_unit_tb
// Drives poll words into the button detector and takes its result words.
// A hand-written press/release sequence runs first at the reset settings,
// then a click saturation run, then random button gestures with contact
// bounce under a series of register settings. Polls come in bursts with
// gaps and the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module button_click_longpress_detector_unit_tb;
	import bcld_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_POLLS   = 480;
	localparam int PHASE_POLLS    = 60;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata   = '0;   // [31:0] time_now, [32] pin_level, rest zero
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;          // [2:0] event_kind, [18:3] event_count,
	                               // [19] button_state, rest zero
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;

	int          mismatches;
	int          words_due;

	// Sender and stimulus state
	logic [31:0] tnow;
	int          burst_left = 0;
	int          polls_sent = 0;
	int          cfg_settle = SETTLE_TIME_RST;
	int          cfg_hold   = LONG_THRESHOLD_RST;
	int          cfg_gap    = CLICK_GAP_RST;
	int          cfg_rpt    = REPEAT_IVL_RST;

	// Receiver pattern state
	int          ready_mode = 0;
	int          ready_left = 0;
	int          quiet      = 0;

	always #2 clk = ~clk;

	button_click_longpress_detector_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bcld_event_checker event_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (mismatches),
		.words_due (words_due)
	);

	// Stall the result side: switch among four ready patterns picked at random
	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_mode <= $urandom_range(0, 3);
			ready_left <= $urandom_range(8, 64);
		end else begin
			ready_left <= ready_left - 1;
		end
		case (ready_mode)
			0:       m_tready <= 1'b1;
			1:       m_tready <= ($urandom_range(0, 3) != 0);
			2:       m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= ~m_tready;
		endcase
	end

	// End the run when no word has moved on any channel for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Send one poll word, opening a new burst after a random gap
	task automatic send_poll(input logic [31:0] stamp, input logic level);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, level, stamp};
		do @(posedge clk); while (!s_tready);
		burst_left--;
		polls_sent++;
	endtask

	task automatic step(input int unsigned dt, input logic level);
		tnow = tnow + dt;
		send_poll(tnow, level);
	endtask

	// Hold the pin at one level for a span, split into a few polls
	task automatic hold_span(input int span, input logic level);
		int n;
		n = $urandom_range(2, 8);
		repeat (n) step(span / n + $urandom_range(0, 1), level);
		if ($urandom_range(0, 2) == 0)
			repeat (3) step(1, level);
	endtask

	task automatic bounce();
		repeat ($urandom_range(0, 3))
			step($urandom_range(0, cfg_settle), 1'($urandom_range(0, 1)));
	endtask

	// One press and release with bounce, or a short run of noise polls
	task automatic gesture();
		int hold_for;
		int rest_for;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 4)) begin
				tnow = $urandom;
				step(0, 1'($urandom_range(0, 1)));
			end
			return;
		end
		case ($urandom_range(0, 2))
			0:       hold_for = cfg_settle + $urandom_range(0, cfg_hold);
			1:       hold_for = cfg_settle + cfg_hold + $urandom_range(0, 4) - 2;
			default: hold_for = cfg_settle + cfg_hold + cfg_rpt * $urandom_range(1, 5)
			                    + $urandom_range(0, cfg_rpt);
		endcase
		case ($urandom_range(0, 2))
			0:       rest_for = cfg_settle + $urandom_range(0, cfg_gap);
			1:       rest_for = cfg_settle + cfg_gap + $urandom_range(0, 4) - 2;
			default: rest_for = cfg_settle + cfg_gap + $urandom_range(0, cfg_gap);
		endcase
		if (hold_for < 0) hold_for = 0;
		if (rest_for < 0) rest_for = 0;
		bounce();
		hold_span(hold_for, 1'b0);
		bounce();
		hold_span(rest_for, 1'b1);
	endtask

	// Drop valid and wait until every result word has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (words_due != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		burst_left = 0;
	endtask

	// Write all four registers, then one write to an unused index
	task automatic configure(input logic [15:0] st, input logic [15:0] lp,
	                         input logic [15:0] cg, input logic [15:0] ri);
		logic [7:0]  idx [5];
		logic [15:0] val [5];
		idx = '{REG_SETTLE_TIME, REG_LONG_THRESHOLD, REG_CLICK_GAP, REG_REPEAT_IVL,
		        8'($urandom_range(4, 255))};
		val = '{st, lp, cg, ri, 16'($urandom)};
		for (int k = 0; k < 5; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[k];
			cfg_data  <= val[k];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		cfg_settle = st;
		cfg_hold   = lp;
		cfg_gap    = cg;
		cfg_rpt    = ri;
	endtask

	initial begin
		int unsigned plan_at [26];
		logic        plan_pin [26];
		int          random_goal;
		int          phase_start;

		plan_at  = '{0, 1, 10, 11, 20, 30, 1011, 1012, 1112, 1113, 1120, 1130, 1200,
		             1210, 1300, 1310, 1320, 1330, 1340, 1350, 1550, 1551, 1600, 1610,
		             2600, 2610};
		plan_pin = '{1, 0, 1, 0, 1, 0, 0, 0, 0, 0, 1, 1, 0,
		             0, 1, 1, 0, 0, 1, 1, 1, 1, 0, 0,
		             1, 1};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: bounce ignored during settle, press exactly at settle,
		// settle ending on the old level, long-press and repeat boundaries,
		// long release clearing clicks, a double click reported after the gap,
		// and a release exactly at the threshold. The counter wraps midway.
		tnow = 32'hFFFF_FC00;
		for (int k = 0; k < 26; k++)
			send_poll(tnow + plan_at[k], plan_pin[k]);
		tnow = tnow + plan_at[25];
		drain();

		// Click count saturates at its maximum before the burst is reported
		configure(16'd1, 16'hFFFF, 16'hFFFF, 16'd1);
		repeat (260) begin
			step(1, 1'b0);
			step(1, 1'b0);
			step(1, 1'b1);
			step(1, 1'b1);
		end
		step(70000, 1'b1);
		step(1, 1'b1);
		drain();

		// Random gestures under a rotation of register settings
		random_goal = polls_sent + RANDOM_POLLS;
		for (int p = 0; polls_sent < random_goal; p++) begin
			if (p > 0) drain();
			case (p % 8)
				0: configure(SETTLE_TIME_RST, LONG_THRESHOLD_RST, CLICK_GAP_RST,
				             REPEAT_IVL_RST);
				1: configure(16'd1, 16'd1, 16'd1, 16'd1);
				2: configure(16'd0, 16'd0, 16'd0, 16'd0);
				3: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				4: configure(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
				             16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)));
				5: configure(16'd1, 16'hFFFF, 16'd1, 16'hFFFF);
				6: configure(16'hFFFF, 16'd1, 16'hFFFF, 16'd1);
				default: configure(16'($urandom), 16'($urandom), 16'($urandom),
				                   16'($urandom));
			endcase
			if ($urandom_range(0, 1))
				tnow = 32'hFFFF_FFFF - $urandom_range(0, 5000);
			phase_start = polls_sent;
			while (polls_sent - phase_start < PHASE_POLLS && polls_sent < random_goal)
				gesture();
		end
		drain();

		if (mismatches == 0 && words_due == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: filelist.f
rtl/bcld_pkg.sv
rtl/bcld_core.sv
rtl/button_click_longpress_detector_unit.sv
tb/bcld_event_checker.sv
tb/button_click_longpress_detector_unit_tb.sv
